[hw/rtl/kf_pkg.sv]
// ----------------------------------------------------------------------------
// Keyword finder package
// Shared types, character codes and helper functions for the keyword finder.
// ----------------------------------------------------------------------------
package kf_pkg;

  localparam int KEY_MAX_DEF = 8;
  localparam int MAX_LEN_DEF = 4096;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int KLEN_CFG_W  = 4;
  localparam int POS_W       = 12;
  localparam int DEPTH_W     = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEED_BEFORE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEED_AFTER  = 3'd4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // One classified character on its way from the lexer to the matcher.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       keep;
    logic       elig;
  } kf_item_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key, input int p);
    logic [7:0] b;
    b = 8'h00;
    if (p < KEY_BYTES) begin
      b = key[8*p +: 8];
    end
    return b;
  endfunction

endpackage

[hw/rtl/kf_front.sv]
// ----------------------------------------------------------------------------
// Keyword finder lexer front end
// Tracks quotes and parenthesis depth and marks where a match may start.
// ----------------------------------------------------------------------------
module kf_front #(
  parameter int MAX_LEN = kf_pkg::MAX_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             need_before_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       ch_i,
  input  logic             last_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output kf_pkg::kf_item_t item_o
);
  import kf_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0]      cnt_q, cnt_d;
  logic               quote_q, quote_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [7:0]         prev_q, prev_d;

  logic               keep, lex, quote_n, prev_ok, elig, fire;
  logic [DEPTH_W-1:0] depth_n;

  assign keep    = cnt_q < CW'(MAX_LEN);
  assign lex     = keep && !(need_before_i && (cnt_q == '0));
  assign quote_n = quote_q ^ (lex && (ch_i == CH_QUOTE));
  assign prev_ok = is_space(prev_q) || (prev_q == CH_RPAREN) || (prev_q == CH_QUOTE);

  always_comb begin
    depth_n = depth_q;
    if (lex && !quote_n) begin
      if (ch_i == CH_LPAREN) begin
        depth_n = depth_q + 1'b1;
      end else if (ch_i == CH_RPAREN) begin
        depth_n = depth_q - 1'b1;
      end
    end
  end

  assign elig = lex && !quote_n && (depth_n == '0) && (!need_before_i || prev_ok);

  assign in_ready_o   = item_ready_i;
  assign item_valid_o = in_valid_i;
  assign fire         = in_valid_i && item_ready_i;
  assign item_o       = '{ch: ch_i, last: last_i, keep: keep, elig: elig};

  always_comb begin
    cnt_d   = cnt_q;
    quote_d = quote_q;
    depth_d = depth_q;
    prev_d  = prev_q;
    if (fire) begin
      if (last_i) begin
        cnt_d   = '0;
        quote_d = 1'b0;
        depth_d = '0;
        prev_d  = 8'h00;
      end else if (keep) begin
        cnt_d   = cnt_q + 1'b1;
        quote_d = quote_n;
        depth_d = depth_n;
        prev_d  = ch_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      quote_q <= 1'b0;
      depth_q <= '0;
      prev_q  <= 8'h00;
    end else begin
      cnt_q   <= cnt_d;
      quote_q <= quote_d;
      depth_q <= depth_d;
      prev_q  <= prev_d;
    end
  end

endmodule

[hw/rtl/kf_fifo.sv]
// ----------------------------------------------------------------------------
// Keyword finder item queue
// Two-entry queue of classified characters between lexer and matcher.
// ----------------------------------------------------------------------------
module kf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  kf_pkg::kf_item_t push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output kf_pkg::kf_item_t pop_item_o
);
  import kf_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  kf_item_t        mem_q [FIFO_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [NW-1:0]   num_q;
  logic            push, pop;

  assign push_ready_o = num_q < NW'(FIFO_DEPTH);
  assign pop_valid_o  = num_q != '0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      num_q <= num_q + NW'(push) - NW'(pop);
    end
  end

endmodule

[hw/rtl/kf_back.sv]
// ----------------------------------------------------------------------------
// Keyword finder matcher back end
// Holds the character window, compares it with the keyword and keeps the
// first match, then presents one result word per expression.
// ----------------------------------------------------------------------------
module kf_back #(
  parameter int KEY_MAX = kf_pkg::KEY_MAX_DEF,
  parameter int MAX_LEN = kf_pkg::MAX_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [kf_pkg::KLEN_CFG_W-1:0] key_len_i,
  input  logic [kf_pkg::KEY_W-1:0]      key_first_i,
  input  logic [kf_pkg::KEY_W-1:0]      key_second_i,
  input  logic                          need_after_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  kf_pkg::kf_item_t              item_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          res_found_o,
  output logic [kf_pkg::POS_W-1:0]      res_pos_o
);
  import kf_pkg::*;

  localparam int WIN = KEY_MAX + 1;
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int LW  = $clog2(WIN);

  logic [7:0]       win_q [WIN];
  logic [7:0]       win_n [WIN];
  logic [WIN-1:0]   elig_q, elig_n;
  logic [CW-1:0]    cnt_q, cnt_n;
  logic             seen_q, seen_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q;
  logic             out_found_q;
  logic [POS_W-1:0] out_pos_q;

  logic [LW-1:0]    klen;
  logic [7:0]       kb1 [KEY_MAX];
  logic [7:0]       kb2 [KEY_MAX];
  logic             eq [WIN][KEY_MAX];
  logic [WIN-1:0]   hit_mid, hit_end;
  logic             pop, take_last, cand_mid, cand_end;
  logic [POS_W-1:0] pos_mid, pos_end;

  always_comb begin
    if (key_len_i == '0) begin
      klen = LW'(1);
    end else if (int'(key_len_i) > KEY_MAX) begin
      klen = LW'(KEY_MAX);
    end else begin
      klen = LW'(key_len_i);
    end
  end

  always_comb begin
    for (int p = 0; p < KEY_MAX; p++) begin
      kb1[p] = key_byte(key_first_i, p);
      kb2[p] = key_byte(key_second_i, p);
    end
  end

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      win_n[j] = win_q[j];
    end
    elig_n = elig_q;
    cnt_n  = cnt_q;
    if (item_i.keep) begin
      win_n[0] = item_i.ch;
      for (int j = 1; j < WIN; j++) begin
        win_n[j] = win_q[j-1];
      end
      elig_n = {elig_q[WIN-2:0], item_i.elig};
      cnt_n  = cnt_q + 1'b1;
    end
  end

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      for (int p = 0; p < KEY_MAX; p++) begin
        eq[j][p] = (win_n[j] == kb1[p]) || (win_n[j] == kb2[p]);
      end
    end
  end

  // A keyword of length L matches either one character before the newest one
  // (the newest then follows it) or ending on the newest character.
  always_comb begin
    hit_mid = '0;
    hit_end = '0;
    for (int l = 1; l < WIN; l++) begin
      hit_mid[l] = 1'b1;
      hit_end[l] = 1'b1;
      for (int p = 0; p < KEY_MAX; p++) begin
        if (p < l) begin
          hit_mid[l] = hit_mid[l] & eq[l-p][p];
          hit_end[l] = hit_end[l] & eq[l-1-p][p];
        end
      end
    end
  end

  assign cand_mid = item_i.keep && (cnt_q >= CW'(klen)) && elig_n[klen]
                    && (!need_after_i || is_space(item_i.ch)) && hit_mid[klen];
  assign cand_end = item_i.last && (cnt_n >= CW'(klen)) && elig_n[klen - 1'b1]
                    && hit_end[klen];
  assign pos_mid  = POS_W'(cnt_q - CW'(klen));
  assign pos_end  = POS_W'(cnt_n - CW'(klen));

  always_comb begin
    seen_d = seen_q;
    pos_d  = pos_q;
    if (!seen_q) begin
      if (cand_mid) begin
        seen_d = 1'b1;
        pos_d  = pos_mid;
      end else if (cand_end) begin
        seen_d = 1'b1;
        pos_d  = pos_end;
      end
    end
  end

  assign item_ready_o = !item_i.last || !out_valid_q || res_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign take_last    = pop && item_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < WIN; j++) begin
        win_q[j] <= 8'h00;
      end
      elig_q      <= '0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (item_i.last) begin
          for (int j = 0; j < WIN; j++) begin
            win_q[j] <= 8'h00;
          end
          elig_q <= '0;
          cnt_q  <= '0;
          seen_q <= 1'b0;
          pos_q  <= '0;
        end else begin
          for (int j = 0; j < WIN; j++) begin
            win_q[j] <= win_n[j];
          end
          elig_q <= elig_n;
          cnt_q  <= cnt_n;
          seen_q <= seen_d;
          pos_q  <= pos_d;
        end
      end
      if (take_last) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_last) begin
      out_found_q <= seen_d;
      out_pos_q   <= seen_d ? pos_d : '0;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_found_o = out_found_q;
  assign res_pos_o   = out_pos_q;

endmodule

[hw/rtl/lexer_aware_keyword_finder.sv]
// ----------------------------------------------------------------------------
// Lexer-aware keyword finder
// Finds the first place outside quotes and at parenthesis depth zero where a
// configured keyword of up to KEY_MAX characters occurs in an expression.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata = ch, tlast = last
//   m_axis    out        tdata = position (zero padded), tuser = found
//   cfg       in         write of one register by index
//
// One character word is taken every cycle while the queue has room; the lexer
// and the window compare each work combinationally on registered state, with a
// two-word queue between them. The result word is registered when the matcher
// takes the word marked tlast. While a result waits, characters keep flowing
// until the next tlast word reaches the matcher and the queue behind it fills.
// Reset is asynchronous; it clears all expression state and the registers, but key length resets to one.
// ----------------------------------------------------------------------------
module lexer_aware_keyword_finder #(
  parameter int KEY_MAX = kf_pkg::KEY_MAX_DEF,
  parameter int MAX_LEN = kf_pkg::MAX_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] ch
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [11:0] position
  output logic                         m_axis_tuser,   // [0] found
  input  logic                         cfg_we_i,
  input  logic [kf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kf_pkg::KEY_W-1:0]     cfg_data_i
);
  import kf_pkg::*;

  logic [KLEN_CFG_W-1:0] key_len_q;
  logic [KEY_W-1:0]      key_first_q, key_second_q;
  logic                  need_before_q, need_after_q;

  kf_item_t         f_item, b_item;
  logic             f_valid, f_ready, b_valid, b_ready;
  logic             res_found;
  logic [POS_W-1:0] res_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q     <= KLEN_CFG_W'(1);
      key_first_q   <= '0;
      key_second_q  <= '0;
      need_before_q <= 1'b0;
      need_after_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_LEN:     key_len_q     <= cfg_data_i[KLEN_CFG_W-1:0];
        REG_KEY_FIRST:   key_first_q   <= cfg_data_i;
        REG_KEY_SECOND:  key_second_q  <= cfg_data_i;
        REG_NEED_BEFORE: need_before_q <= cfg_data_i[0];
        REG_NEED_AFTER:  need_after_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  kf_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .need_before_i (need_before_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .ch_i          (s_axis_tdata),
    .last_i        (s_axis_tlast),
    .item_valid_o  (f_valid),
    .item_ready_i  (f_ready),
    .item_o        (f_item)
  );

  kf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  kf_back #(
    .KEY_MAX (KEY_MAX),
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_len_i    (key_len_q),
    .key_first_i  (key_first_q),
    .key_second_i (key_second_q),
    .need_after_i (need_after_q),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_found_o  (res_found),
    .res_pos_o    (res_pos)
  );

  assign m_axis_tdata = {{(16 - POS_W){1'b0}}, res_pos};
  assign m_axis_tuser = res_found;

endmodule

[hw/rtl/kf_checker.sv]
// ----------------------------------------------------------------------------
// Keyword finder port checker
// Watches the ports of the keyword finder and flags inconsistent results.
// ----------------------------------------------------------------------------
module kf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import kf_pkg::*;

  logic [3:0] pend_q;
  logic       s_last_fire, m_fire;

  assign s_last_fire = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign m_fire      = m_axis_tvalid && m_axis_tready;

  // Expressions whose final word has been taken but whose result is not yet out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(s_last_fire) - 4'(m_fire);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 4'd0)
    else $error("result word without a finished expression");

  a_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'h0000)
    else $error("position not zero when nothing was found");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:POS_W] == '0)
    else $error("padding bits of the result word are set");

endmodule

bind lexer_aware_keyword_finder kf_checker u_kf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/keyword_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword finder result checker
// Watches the character, result and register channels of the keyword finder.
// It keeps its own copy of the registers and of the expression state, works
// out the found flag and position for every word marked last, and compares
// each result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module keyword_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,
  input  logic                         s_axis_tlast,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [15:0]                  m_axis_tdata,
  input  logic                         m_axis_tuser,
  input  logic                         cfg_we_i,
  input  logic [kf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kf_pkg::KEY_W-1:0]     cfg_data_i,
  output int                           err_cnt_o,
  output int                           pending_o
);
  import kf_pkg::*;

  localparam int WIN = KEY_MAX_DEF + 1;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } hit_t;

  logic [KLEN_CFG_W-1:0] key_len_r;
  logic [KEY_W-1:0]      spell_a;
  logic [KEY_W-1:0]      spell_b;
  logic                  want_before;
  logic                  want_after;

  logic [7:0]            recent [WIN];
  logic                  can_start [WIN];
  int                    seen_chars;
  logic                  quoted;
  logic [DEPTH_W-1:0]    depth;
  logic                  hit_seen;
  logic [POS_W-1:0]      hit_pos;
  hit_t                  expected_hits [$];

  function automatic logic blank(input logic [7:0] c);
    logic b;
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: b = 1'b1;
      default:                        b = 1'b0;
    endcase
    return b;
  endfunction

  function automatic int span();
    if (key_len_r == '0) return 1;
    if (key_len_r > KEY_MAX_DEF) return KEY_MAX_DEF;
    return int'(key_len_r);
  endfunction

  // The keyword is compared with its first character at recent[top].
  function automatic logic spelled_at(input int top, input int klen);
    logic       ok;
    logic [7:0] c;
    ok = 1'b1;
    for (int p = 0; p < klen; p++) begin
      c = recent[top - p];
      if (c != spell_a[8*p +: 8] && c != spell_b[8*p +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic note_hit(input int pos);
    if (!hit_seen) begin
      hit_seen = 1'b1;
      hit_pos  = pos[POS_W-1:0];
    end
  endtask

  task automatic clear_line();
    for (int i = 0; i < WIN; i++) begin
      recent[i]    = '0;
      can_start[i] = 1'b0;
    end
    seen_chars = 0;
    quoted     = 1'b0;
    depth      = '0;
    hit_seen   = 1'b0;
    hit_pos    = '0;
  endtask

  task automatic take_char(input logic [7:0] c, input logic fin);
    int         klen;
    int         n;
    logic [7:0] prev;
    logic       el;
    hit_t       h;
    klen = span();
    if (seen_chars < MAX_LEN_DEF) begin
      n    = seen_chars;
      prev = recent[0];
      el   = 1'b0;
      // With the before-check on, the first character is never lexed.
      if (!(want_before && n == 0)) begin
        if (c == CH_QUOTE) quoted = ~quoted;
        if (!quoted) begin
          if (c == CH_LPAREN) depth = depth + 1'b1;
          else if (c == CH_RPAREN) depth = depth - 1'b1;
          if (depth == '0) begin
            el = !(want_before &&
                   !(blank(prev) || prev == CH_RPAREN || prev == CH_QUOTE));
          end
        end
      end
      for (int d = WIN - 1; d > 0; d--) begin
        recent[d]    = recent[d-1];
        can_start[d] = can_start[d-1];
      end
      recent[0]    = c;
      can_start[0] = el;
      // The newest character is the one that follows a candidate klen back.
      if (n >= klen && can_start[klen] && !(want_after && !blank(c))) begin
        if (spelled_at(klen, klen)) note_hit(n - klen);
      end
      seen_chars = n + 1;
    end
    if (fin) begin
      if (seen_chars >= klen && can_start[klen-1]) begin
        if (spelled_at(klen - 1, klen)) note_hit(seen_chars - klen);
      end
      h.found = hit_seen;
      h.pos   = hit_seen ? hit_pos : '0;
      expected_hits.push_back(h);
      clear_line();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    hit_t want;
    if (!rst_ni) begin
      key_len_r   = 4'd1;
      spell_a     = '0;
      spell_b     = '0;
      want_before = 1'b0;
      want_after  = 1'b0;
      clear_line();
      expected_hits.delete();
      err_cnt_o   = 0;
      pending_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hits.size() == 0) begin
          err_cnt_o++;
          $display("%0t: result word found=%0b position=%0d arrived with none expected",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = expected_hits.pop_front();
          if (m_axis_tuser !== want.found) begin
            err_cnt_o++;
            $display("%0t: found expected %0b actual %0b",
                     $time, want.found, m_axis_tuser);
          end
          if (m_axis_tdata !== {4'b0000, want.pos}) begin
            err_cnt_o++;
            $display("%0t: position expected %0d actual %0d",
                     $time, want.pos, m_axis_tdata);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_LEN:     key_len_r   = cfg_data_i[KLEN_CFG_W-1:0];
          REG_KEY_FIRST:   spell_a     = cfg_data_i;
          REG_KEY_SECOND:  spell_b     = cfg_data_i;
          REG_NEED_BEFORE: want_before = cfg_data_i[0];
          REG_NEED_AFTER:  want_after  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_char(s_axis_tdata, s_axis_tlast);
      pending_o = expected_hits.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword finder testbench
// Drives expressions into the keyword finder under a series of register
// settings: a short directed set and random expressions built mostly from
// keyword spellings, quotes, parentheses and blanks. Both channels stall at
// random; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import kf_pkg::*;

  localparam int WATCH_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = 8'h00;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [15:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = REG_KEY_LEN;
  logic [KEY_W-1:0]     cfg_data_i    = '0;

  int                   err_cnt;
  int                   pending;
  logic [KEY_W-1:0]     spell_a;
  logic [KEY_W-1:0]     spell_b;
  int                   key_n       = 1;
  bit                   gappy       = 1'b1;
  int                   hold_req    = 0;
  int                   hold_done   = 0;
  int                   quiet       = 0;
  int                   random_sent = 0;

  always #6 clk_i = ~clk_i;

  lexer_aware_keyword_finder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  keyword_checker hit_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending)
  );

  function automatic logic [KEY_W-1:0] spelled(input string s);
    logic [KEY_W-1:0] w;
    w = '0;
    for (int k = 0; k < s.len() && k < KEY_BYTES; k++) w[8*k +: 8] = s[k];
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gappy || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic setup(input logic [3:0] len, input logic [KEY_W-1:0] a,
                       input logic [KEY_W-1:0] b, input logic nb, input logic na);
    write_reg(REG_KEY_LEN, {60'd0, len});
    write_reg(REG_KEY_FIRST, a);
    write_reg(REG_KEY_SECOND, b);
    write_reg(REG_NEED_BEFORE, {63'd0, nb});
    write_reg(REG_NEED_AFTER, {63'd0, na});
    spell_a = a;
    spell_b = b;
    key_n   = (len == 4'd0) ? 1 : ((len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(len));
  endtask

  // The block is idle once every result is in and its pipeline has drained.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_expr(input int max_len);
    logic [7:0] chars [$];
    int         target;
    int         r;
    int         cut;
    target = $urandom_range(1, max_len);
    while (chars.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, key_n) : key_n;
        for (int k = 0; k < cut; k++) begin
          chars.push_back($urandom_range(0, 1) ? spell_a[8*k +: 8] : spell_b[8*k +: 8]);
        end
      end else if (r < 52) begin
        case ($urandom_range(0, 3))
          0:       chars.push_back(CH_SPACE);
          1:       chars.push_back(CH_TAB);
          2:       chars.push_back(CH_CR);
          default: chars.push_back(CH_LF);
        endcase
      end else if (r < 62) begin
        chars.push_back(CH_QUOTE);
      end else if (r < 76) begin
        chars.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
      end else if (r < 94) begin
        chars.push_back(8'(8'h61 + $urandom_range(0, 5)));
      end else begin
        chars.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    random_sent += chars.size();
  endtask

  initial begin : receiver
    int stall_left;
    int steady_left;
    stall_left  = 0;
    steady_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done     = hold_req;
        m_axis_tready = 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (steady_left > 0) begin
          steady_left--;
        end else if ($urandom_range(0, 99) < 4) begin
          steady_left = $urandom_range(30, 150);
        end else if ($urandom_range(0, 99) < 35) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 50)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i || !rst_ni) begin
      quiet <= 0;
    end else if (quiet >= WATCH_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic [3:0]       len;
    logic             nb;
    logic             na;
    int               r;
    int               target;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Before- and after-checks, an unlexed leading quote and a short line.
    setup(4'd2, spelled("ab"), spelled("AB"), 1'b1, 1'b1);
    send_str("\"x ab");
    send_str(")ab");
    send_str("a");
    settle();
    // Zero length acts as one; extreme bytes inside and outside parentheses.
    setup(4'd0, '0, '1, 1'b0, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(CH_LPAREN, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_RPAREN, 1'b0);
    send_char(8'hFF, 1'b1);
    settle();
    // An oversized length acts as the maximum.
    setup(4'd15, spelled("abcdefgh"), spelled("ABCDEFGH"), 1'b0, 1'b1);
    send_str("x abcdefgh");
    settle();

    for (int ph = 0; random_sent < RANDOM_ITEMS; ph++) begin
      len = 4'($urandom_range(1, 8));
      nb  = 1'($urandom_range(0, 1));
      na  = 1'($urandom_range(0, 1));
      for (int k = 0; k < KEY_BYTES; k++) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          a[8*k +: 8] = 8'(8'h61 + $urandom_range(0, 5));
          b[8*k +: 8] = a[8*k +: 8] ^ 8'h20;
        end else begin
          a[8*k +: 8] = (r < 90) ? CH_QUOTE : ((r < 95) ? CH_RPAREN : CH_SPACE);
          b[8*k +: 8] = 8'($urandom_range(0, 255));
        end
      end
      case (ph % 6)
        0: begin
          len = 4'd1;
          nb  = 1'b0;
          na  = 1'b0;
        end
        1: begin
          len = 4'd8;
          nb  = 1'b1;
          na  = 1'b1;
        end
        2: len = 4'd0;
        3: begin
          len = 4'd15;
          a   = '1;
          b   = '0;
        end
        default: ;
      endcase
      gappy = (ph % 3 != 2);
      setup(len, a, b, nb, na);
      if (ph == 4) begin
        // Results pile up behind a long receiver hold while words keep coming.
        gappy = 1'b0;
        hold_req++;
        repeat (60) send_expr(3);
        gappy = 1'b1;
      end
      target = random_sent + 180;
      while (random_sent < target) begin
        send_expr(($urandom_range(0, 9) == 0) ? 60 : 20);
      end
      settle();
    end

    settle();
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
